[sv/rc_channel_frame_decoder_defines.svh]
// Assertion macros shared by the frame decoder RTL.
// Included by every file that carries concurrent assertions.
`ifndef RC_CHANNEL_FRAME_DECODER_DEFINES_SVH
`define RC_CHANNEL_FRAME_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define RCFD_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("rcfd assertion failed");
`define RCFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rcfd assertion failed");
`else
`define RCFD_ASSERT_ALWAYS(lbl, expr)
`define RCFD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/rcfd_pkg.sv]
// Shared types, constants and the CRC-8 step of the RC channel frame decoder.
// No dependencies; the RTL modules refer to it by scoped names.
package rcfd_pkg;

  localparam logic [7:0] AddrByte = 8'hEE;
  localparam logic [7:0] TypeByte = 8'h16;
  localparam logic [7:0] CrcPoly  = 8'hD5;
  localparam int NumChannels = 16;
  localparam int MaxChanBits = 16;
  localparam int QueueDepth  = 2;
  localparam int CfgW        = 11;
  localparam logic [10:0] AnalogMax      = 11'd2047;
  localparam logic [10:0] OffsetReset    = 11'd173;
  localparam logic [10:0] ThresholdReset = 11'd992;

  typedef enum logic [0:0] {
    CFG_ANALOG_OFFSET    = 1'b0,
    CFG_BUTTON_THRESHOLD = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [CfgW-1:0] analog_offset;
    logic [CfgW-1:0] button_threshold;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_CHAN   = 2'd1,
    OP_COMMIT = 2'd2
  } op_code_t;

  // One command from the parser to the channel back end.
  typedef struct packed {
    op_code_t               code;
    logic [3:0]             chan;
    logic [MaxChanBits-1:0] raw;
  } op_t;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[sv/rcfd_channel_if.sv]
// Valid/ready channel interfaces for received bytes and decoded frames.
// Depends on nothing; used by the top level and the back end.
interface rcfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface rcfd_result_if;
  logic        valid;
  logic        ready;
  logic [10:0] throttle;
  logic [10:0] yaw;
  logic [10:0] pitch;
  logic [10:0] roll;
  logic [10:0] aux_one;
  logic [10:0] aux_two;
  logic [10:0] aux_three;
  logic [10:0] aux_four;
  logic [7:0]  button_bits;
  logic        values_changed;
  modport source (output valid, output throttle, output yaw, output pitch, output roll,
                  output aux_one, output aux_two, output aux_three, output aux_four,
                  output button_bits, output values_changed, input ready);
  modport sink (input valid, input throttle, input yaw, input pitch, input roll,
                input aux_one, input aux_two, input aux_three, input aux_four,
                input button_bits, input values_changed, output ready);
endinterface

[sv/rcfd_queue.sv]
// Short command queue between the frame parser and the channel back end.
// Depends on rcfd_pkg and the assertion macro header.
`include "rc_channel_frame_decoder_defines.svh"

module rcfd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rcfd_pkg::op_t   push_op,
  output logic            full,
  input  logic            pop,
  output rcfd_pkg::op_t   pop_op,
  output logic            empty
);

  localparam int Depth  = rcfd_pkg::QueueDepth;
  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  rcfd_pkg::op_t     slots [Depth];
  logic [PtrW-1:0]   wptr;
  logic [PtrW-1:0]   rptr;
  logic [CountW-1:0] count;

  assign full   = (count == CountW'(Depth));
  assign empty  = (count == '0);
  assign pop_op = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `RCFD_ASSERT_ALWAYS(a_no_push_when_full, !(push && full))
  `RCFD_ASSERT_ALWAYS(a_no_pop_when_empty, !(pop && empty))

endmodule

[sv/rcfd_front.sv]
// Byte parser: frame sync, CRC-8 check and LSB-first channel unpacking.
// Depends on rcfd_pkg and the assertion macro header; feeds rcfd_queue.
`include "rc_channel_frame_decoder_defines.svh"

module rcfd_front #(
  parameter int CHANNEL_BITS = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rx_valid,
  output logic          rx_ready,
  input  logic [7:0]    rx_byte,
  input  logic          q_full,
  output logic          push,
  output rcfd_pkg::op_t push_op
);

  localparam int RawW         = rcfd_pkg::MaxChanBits;
  localparam int PayloadBytes = (rcfd_pkg::NumChannels * CHANNEL_BITS + 7) / 8;
  localparam logic [7:0] FrameLen = 8'(PayloadBytes + 2);
  localparam int BufW   = CHANNEL_BITS + 7;
  localparam int FillW  = $clog2(BufW + 1);
  localparam int CountW = $clog2(PayloadBytes + 1);

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LEN     = 5'b00010,
    PH_TYPE    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CRC     = 5'b10000
  } phase_t;

  phase_t            phase, phase_next;
  logic [CountW-1:0] byte_count, byte_count_next;
  logic [7:0]        crc, crc_next;
  logic [BufW-1:0]   bit_buffer, bit_buffer_next;
  logic [FillW-1:0]  bit_fill, bit_fill_next;
  logic [4:0]        chan_idx, chan_idx_next;

  logic             take;
  logic [7:0]       crc_step;
  logic [BufW-1:0]  merged;
  logic [FillW-1:0] fill_sum;

  assign rx_ready = !q_full;
  assign take     = rx_valid && rx_ready;
  assign crc_step = rcfd_pkg::crc8_step(crc, rx_byte);
  assign merged   = bit_buffer | (BufW'(rx_byte) << bit_fill);
  assign fill_sum = bit_fill + FillW'(8);

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    crc_next        = crc;
    bit_buffer_next = bit_buffer;
    bit_fill_next   = bit_fill;
    chan_idx_next   = chan_idx;
    push            = 1'b0;
    push_op.code    = rcfd_pkg::OP_CHAN;
    push_op.chan    = chan_idx[3:0];
    push_op.raw     = RawW'(merged[CHANNEL_BITS-1:0]);
    if (take) begin
      case (phase)
        PH_HUNT: begin
          if (rx_byte == rcfd_pkg::AddrByte) begin
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          phase_next = (rx_byte == FrameLen) ? PH_TYPE : PH_HUNT;
        end
        PH_TYPE: begin
          if (rx_byte != rcfd_pkg::TypeByte) begin
            phase_next = PH_HUNT;
          end else begin
            crc_next        = rcfd_pkg::crc8_step(8'h00, rx_byte);
            byte_count_next = '0;
            bit_buffer_next = '0;
            bit_fill_next   = '0;
            chan_idx_next   = '0;
            push            = 1'b1;
            push_op.code    = rcfd_pkg::OP_START;
            phase_next      = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          crc_next        = crc_step;
          bit_buffer_next = merged;
          bit_fill_next   = fill_sum;
          if (fill_sum >= FillW'(CHANNEL_BITS)) begin
            if (chan_idx < 5'(rcfd_pkg::NumChannels)) begin
              push          = 1'b1;
              chan_idx_next = chan_idx + 1'b1;
            end
            bit_buffer_next = merged >> CHANNEL_BITS;
            bit_fill_next   = fill_sum - FillW'(CHANNEL_BITS);
          end
          byte_count_next = byte_count + 1'b1;
          if (byte_count_next >= CountW'(PayloadBytes)) begin
            phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          phase_next = PH_HUNT;
          // A zero residue over type, payload and CRC byte marks a good frame.
          if (crc_step == 8'h00) begin
            push         = 1'b1;
            push_op.code = rcfd_pkg::OP_COMMIT;
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_count <= '0;
      crc        <= '0;
      bit_buffer <= '0;
      bit_fill   <= '0;
      chan_idx   <= '0;
    end else begin
      phase      <= phase_next;
      byte_count <= byte_count_next;
      crc        <= crc_next;
      bit_buffer <= bit_buffer_next;
      bit_fill   <= bit_fill_next;
      chan_idx   <= chan_idx_next;
    end
  end

  `RCFD_ASSERT_ALWAYS(a_chan_idx_bound, chan_idx <= 5'(rcfd_pkg::NumChannels))

endmodule

[sv/rcfd_back.sv]
// Channel back end: analog scaling, button thresholds, staging and commit.
// Depends on rcfd_pkg, rcfd_result_if and the assertion macro header.
`include "rc_channel_frame_decoder_defines.svh"

module rcfd_back #(
  parameter int ANALOG_CHANNELS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  rcfd_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  rcfd_pkg::op_t q_op,
  output logic          pop,
  rcfd_result_if.source res
);

  localparam int RawW = rcfd_pkg::MaxChanBits;

  logic [10:0] staged_analog [8];
  logic [7:0]  staged_buttons;
  logic [10:0] last_analog [8];
  logic [7:0]  last_buttons;

  logic            out_free;
  logic            is_commit;
  logic [RawW-1:0] diff;
  logic [RawW+2:0] times5;
  logic [RawW:0]   quarter;
  logic [10:0]     scaled;
  logic            changed;
  logic            analog_slot;

  assign out_free  = !res.valid || res.ready;
  assign is_commit = (q_op.code == rcfd_pkg::OP_COMMIT);
  assign pop       = !q_empty && (!is_commit || out_free);

  // (v - offset) * 5 / 4, zero at or below the offset, clipped at full scale.
  always_comb begin
    diff    = q_op.raw - RawW'(cfg.analog_offset);
    times5  = ((RawW + 3)'(diff) << 2) + (RawW + 3)'(diff);
    quarter = times5[RawW+2:2];
    if (q_op.raw <= RawW'(cfg.analog_offset)) begin
      scaled = '0;
    end else if (quarter > (RawW + 1)'(rcfd_pkg::AnalogMax)) begin
      scaled = rcfd_pkg::AnalogMax;
    end else begin
      scaled = quarter[10:0];
    end
  end

  assign analog_slot = !q_op.chan[3] && (int'(q_op.chan) < ANALOG_CHANNELS);

  always_comb begin
    changed = (staged_buttons != last_buttons);
    for (int k = 0; k < 8; k++) begin
      if (staged_analog[k] != last_analog[k]) begin
        changed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (q_op.code)
        rcfd_pkg::OP_START: begin
          for (int k = 0; k < 8; k++) begin
            staged_analog[k] <= '0;
          end
          staged_buttons <= '0;
        end
        rcfd_pkg::OP_CHAN: begin
          if (analog_slot) begin
            staged_analog[q_op.chan[2:0]] <= scaled;
          end else if (q_op.chan[3] && (q_op.raw > RawW'(cfg.button_threshold))) begin
            staged_buttons[q_op.chan[2:0]] <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_commit) begin
      res.throttle       <= staged_analog[0];
      res.yaw            <= staged_analog[1];
      res.pitch          <= staged_analog[2];
      res.roll           <= staged_analog[3];
      res.aux_one        <= staged_analog[4];
      res.aux_two        <= staged_analog[5];
      res.aux_three      <= staged_analog[6];
      res.aux_four       <= staged_analog[7];
      res.button_bits    <= staged_buttons;
      res.values_changed <= changed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      for (int k = 0; k < 8; k++) begin
        last_analog[k] <= '0;
      end
      last_buttons <= '0;
    end else begin
      if (pop && is_commit) begin
        res.valid <= 1'b1;
        for (int k = 0; k < 8; k++) begin
          last_analog[k] <= staged_analog[k];
        end
        last_buttons <= staged_buttons;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  `RCFD_ASSERT_ALWAYS(a_commit_needs_room, !(pop && is_commit) || out_free)
  `RCFD_ASSERT_NEXT(a_commit_shows_result, pop && is_commit, res.valid)

endmodule

[sv/rc_channel_frame_decoder.sv]
// Channel   Role    Payload
// rx        sink    rx_byte (8 bit), one serial byte per transaction
// res       source  eight 11-bit analog channels, button_bits, values_changed
// cfg_*     write   cfg_index selects analog_offset or button_threshold
//
// One byte is taken per cycle while the queue has room; the parser decides a byte
// in the cycle it arrives. A good frame's commit goes through the command queue
// to the result register once it is free; a waiting result holds it until taken.
// The command queue is two deep: a stalled result holds only the commit
// command, and rx ready drops once that queue fills.
// Reset is synchronous; it clears parser and queue state, the result valid flag,
// the last frame values, and returns both config registers to their defaults.
module rc_channel_frame_decoder #(
  parameter int ANALOG_CHANNELS = 8,
  parameter int CHANNEL_BITS    = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  rcfd_byte_if.sink                 rx,
  rcfd_result_if.source             res,
  input  logic                      cfg_wen,
  input  logic [0:0]                cfg_index,
  input  logic [rcfd_pkg::CfgW-1:0] cfg_data
);

  rcfd_pkg::cfg_t cfg;
  logic           q_full;
  logic           q_empty;
  logic           push;
  logic           pop;
  rcfd_pkg::op_t  push_op;
  rcfd_pkg::op_t  pop_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.analog_offset    <= rcfd_pkg::OffsetReset;
      cfg.button_threshold <= rcfd_pkg::ThresholdReset;
    end else if (cfg_wen) begin
      case (rcfd_pkg::cfg_index_t'(cfg_index))
        rcfd_pkg::CFG_ANALOG_OFFSET:    cfg.analog_offset    <= cfg_data;
        rcfd_pkg::CFG_BUTTON_THRESHOLD: cfg.button_threshold <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  rcfd_front #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .rx_byte  (rx.rx_byte),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  rcfd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .pop_op  (pop_op),
    .empty   (q_empty)
  );

  rcfd_back #(
    .ANALOG_CHANNELS (ANALOG_CHANNELS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_op    (pop_op),
    .pop     (pop),
    .res     (res)
  );

endmodule
